### hdl/xeil_pkg.sv
package xeil_pkg;

    localparam int WINDOW_BYTES = 15;
    localparam int WIN_W        = 8 * WINDOW_BYTES;
    localparam int IDX_W        = 5;
    localparam int CNT_W        = 4;
    localparam int REP_W        = 6;

    localparam logic [IDX_W-1:0] WIN_END     = IDX_W'(WINDOW_BYTES);
    localparam logic [IDX_W-1:0] LAST_ESC    = IDX_W'(WINDOW_BYTES - 2);

    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_CS    = 8'h2e;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_DS    = 8'h3e;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] PFX_OPSZ  = 8'h66;
    localparam logic [7:0] PFX_ADSZ  = 8'h67;
    localparam logic [7:0] PFX_LOCK  = 8'hf0;
    localparam logic [7:0] PFX_REPNE = 8'hf2;
    localparam logic [7:0] PFX_REP   = 8'hf3;

    localparam logic [3:0] REX_HI    = 4'h4;
    localparam logic [7:0] ESC_0F    = 8'h0f;

    localparam logic [7:0] OP_GRP7   = 8'h01;
    localparam logic [7:0] OP_INVD   = 8'h08;
    localparam logic [7:0] OP_MOVCR  = 8'h20;
    localparam logic [7:0] OP_MOVTOCR = 8'h22;
    localparam logic [7:0] OP_WRMSR  = 8'h30;
    localparam logic [7:0] OP_RDTSC  = 8'h31;
    localparam logic [7:0] OP_RDMSR  = 8'h32;
    localparam logic [7:0] OP_GETSEC = 8'h37;
    localparam logic [7:0] OP_CPUID  = 8'ha2;
    localparam logic [7:0] OP_GRP9   = 8'hc7;

    localparam logic [7:0] RM_VMCALL   = 8'hc1;
    localparam logic [7:0] RM_VMLAUNCH = 8'hc2;
    localparam logic [7:0] RM_VMRESUME = 8'hc3;
    localparam logic [7:0] RM_VMXOFF   = 8'hc4;
    localparam logic [7:0] RM_XSETBV   = 8'hd1;
    localparam logic [7:0] RM_VMFUNC   = 8'hd4;
    localparam logic [7:0] RM_RDTSCP   = 8'hf9;
    localparam logic [2:0] REG_LMSW    = 3'd6;

    localparam logic [1:0] MOD_IND   = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG   = 2'd3;
    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DISP   = 3'd5;

    typedef struct packed {
        logic             ok;
        logic [7:0]       op;
        logic [7:0]       modrm;
        logic [7:0]       sib;
        logic [IDX_W-1:0] nx;
        logic [REP_W-1:0] rep;
    } dec_t;

    function automatic logic is_prefix(input logic [7:0] b);
        logic r;
        unique case (b)
            PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
            PFX_OPSZ, PFX_ADSZ, PFX_LOCK, PFX_REPNE, PFX_REP: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] get_byte(input logic [WIN_W-1:0] w,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        if (idx < WIN_END)
            r = w[{idx[3:0], 3'b000} +: 8];
        else
            r = 8'h00;
        return r;
    endfunction

endpackage

### hdl/xeil_len_calc.sv
module xeil_len_calc
(
    input  xeil_pkg::dec_t dec,
    output logic [3:0]     insn_length,
    output logic           decode_failed,
    output logic           length_mismatch
);

    logic [1:0] mod_f;
    logic [2:0] rm_f;
    logic [4:0] e1;
    logic [4:0] e_sib;
    logic [4:0] opnd_end;
    logic [4:0] len5;
    logic       rm_ok;

    assign mod_f = dec.modrm[7:6];
    assign rm_f  = dec.modrm[2:0];
    assign e1    = dec.nx + 5'd1;
    assign e_sib = e1 + 5'd1;

    assign rm_ok = (dec.modrm == xeil_pkg::RM_VMCALL)   ||
                   (dec.modrm == xeil_pkg::RM_VMLAUNCH) ||
                   (dec.modrm == xeil_pkg::RM_VMRESUME) ||
                   (dec.modrm == xeil_pkg::RM_VMXOFF)   ||
                   (dec.modrm == xeil_pkg::RM_VMFUNC)   ||
                   (dec.modrm == xeil_pkg::RM_XSETBV)   ||
                   (dec.modrm == xeil_pkg::RM_RDTSCP)   ||
                   (dec.modrm[5:3] == xeil_pkg::REG_LMSW);

    always_comb
    begin
        logic [4:0] e;
        e = e1;
        if (mod_f == xeil_pkg::MOD_REG)
            e = e1;
        else if (rm_f == xeil_pkg::RM_SIB)
        begin
            if (e1 >= xeil_pkg::WIN_END)
                e = 5'd31;
            else if (mod_f == xeil_pkg::MOD_IND && dec.sib[2:0] == xeil_pkg::RM_DISP)
                e = e_sib + 5'd4;
            else if (mod_f == xeil_pkg::MOD_DISP8)
                e = e_sib + 5'd1;
            else if (mod_f == xeil_pkg::MOD_DISP32)
                e = e_sib + 5'd4;
            else
                e = e_sib;
        end
        else if (mod_f == xeil_pkg::MOD_IND && rm_f == xeil_pkg::RM_DISP)
            e = e1 + 5'd4;
        else if (mod_f == xeil_pkg::MOD_DISP8)
            e = e1 + 5'd1;
        else if (mod_f == xeil_pkg::MOD_DISP32)
            e = e1 + 5'd4;
        opnd_end = (e <= xeil_pkg::WIN_END) ? e : 5'd0;
    end

    always_comb
    begin
        len5 = 5'd0;
        unique case (dec.op)
            xeil_pkg::OP_INVD, xeil_pkg::OP_WRMSR, xeil_pkg::OP_RDTSC,
            xeil_pkg::OP_RDMSR, xeil_pkg::OP_GETSEC, xeil_pkg::OP_CPUID:
                len5 = dec.nx;
            xeil_pkg::OP_GRP7:
                if (dec.nx < xeil_pkg::WIN_END && rm_ok)
                    len5 = e1;
            xeil_pkg::OP_MOVCR, xeil_pkg::OP_MOVTOCR, xeil_pkg::OP_GRP9:
                if (dec.nx < xeil_pkg::WIN_END)
                    len5 = opnd_end;
            default:
                len5 = 5'd0;
        endcase
        if (!dec.ok)
            len5 = 5'd0;
    end

    assign insn_length     = len5[3:0];
    assign decode_failed   = (len5 == 5'd0);
    assign length_mismatch = (len5 != 5'd0) && ({1'b0, len5} != dec.rep);

endmodule

### hdl/x86_exit_instruction_length.sv
// Exit instruction length decoder.
// Input channel: window_valid / window_stall carry one word made of
// fetch_ok, window_low (bytes 0-7), window_high (bytes 8-14) and
// reported_length. A word is taken at a clock edge with valid high and
// stall low.
// Output channel: length_valid / length_stall carry insn_length,
// decode_failed and length_mismatch, one result word per input word,
// in order.
// Pipeline: three register stages (prefix scan, REX/escape and byte
// select, length compute). An accepted word moves through the stage
// registers to the result register; throughput is one word per cycle
// while the output is not stalled.
// A stall on the output holds the result register; each stage only
// advances into an empty slot or one that is moving on, so bubbles are
// squeezed out and window_stall rises only when all three stages are full
// and the output is stalled.
// Reset (rst_n low, asynchronous) empties the pipeline; no results are
// offered until new words arrive.
module x86_exit_instruction_length
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        window_valid,
    output logic        window_stall,
    input  logic        fetch_ok,
    input  logic [63:0] window_low,
    input  logic [55:0] window_high,
    input  logic [5:0]  reported_length,
    output logic        length_valid,
    input  logic        length_stall,
    output logic [3:0]  insn_length,
    output logic        decode_failed,
    output logic        length_mismatch
);

    logic en1;
    logic en2;
    logic en3;

    logic [xeil_pkg::WIN_W-1:0] win_in;
    logic [xeil_pkg::CNT_W-1:0] pcnt_next;

    logic                       s1_valid_reg;
    logic [xeil_pkg::WIN_W-1:0] s1_win_reg;
    logic [xeil_pkg::CNT_W-1:0] s1_pcnt_reg;
    logic                       s1_fetch_reg;
    logic [xeil_pkg::REP_W-1:0] s1_rep_reg;

    logic [xeil_pkg::IDX_W-1:0] p0;
    logic [xeil_pkg::IDX_W-1:0] p1;
    logic [7:0]                 b_first;
    logic [7:0]                 b_esc;
    xeil_pkg::dec_t             s2_next;
    logic                       s2_valid_reg;
    xeil_pkg::dec_t             s2_reg;

    logic [3:0] len_next;
    logic       failed_next;
    logic       mismatch_next;
    logic       out_valid_reg;
    logic [3:0] len_reg;
    logic       failed_reg;
    logic       mismatch_reg;

    assign en3 = !out_valid_reg || !length_stall;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign window_stall = !en1;

    // stage 1: leading prefix count
    assign win_in = {window_high, window_low};

    always_comb
    begin
        pcnt_next = xeil_pkg::CNT_W'(xeil_pkg::WINDOW_BYTES);
        for (int k = xeil_pkg::WINDOW_BYTES - 1; k >= 0; k--)
        begin
            if (!xeil_pkg::is_prefix(win_in[8*k +: 8]))
                pcnt_next = xeil_pkg::CNT_W'(k);
        end
    end

    // stage 2: optional REX, escape check, opcode/ModRM/SIB select
    assign p0      = {1'b0, s1_pcnt_reg};
    assign b_first = xeil_pkg::get_byte(s1_win_reg, p0);
    assign p1      = p0 + ((b_first[7:4] == xeil_pkg::REX_HI) ? 5'd1 : 5'd0);
    assign b_esc   = xeil_pkg::get_byte(s1_win_reg, p1);

    always_comb
    begin
        s2_next.ok    = s1_fetch_reg && (p1 <= xeil_pkg::LAST_ESC) &&
                        (b_esc == xeil_pkg::ESC_0F);
        s2_next.op    = xeil_pkg::get_byte(s1_win_reg, p1 + 5'd1);
        s2_next.modrm = xeil_pkg::get_byte(s1_win_reg, p1 + 5'd2);
        s2_next.sib   = xeil_pkg::get_byte(s1_win_reg, p1 + 5'd3);
        s2_next.nx    = p1 + 5'd2;
        s2_next.rep   = s1_rep_reg;
    end

    // stage 3: length
    xeil_len_calc u_len
    (
        .dec             (s2_reg),
        .insn_length     (len_next),
        .decode_failed   (failed_next),
        .length_mismatch (mismatch_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= window_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && window_valid)
        begin
            s1_win_reg   <= win_in;
            s1_pcnt_reg  <= pcnt_next;
            s1_fetch_reg <= fetch_ok;
            s1_rep_reg   <= reported_length;
        end
        if (en2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (en3 && s2_valid_reg)
        begin
            len_reg      <= len_next;
            failed_reg   <= failed_next;
            mismatch_reg <= mismatch_next;
        end
    end

    assign length_valid    = out_valid_reg;
    assign insn_length     = len_reg;
    assign decode_failed   = failed_reg;
    assign length_mismatch = mismatch_reg;

endmodule

### hdl/xeil_checker.sv
module xeil_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       window_stall,
    input logic       length_valid,
    input logic       length_stall,
    input logic [3:0] insn_length,
    input logic       decode_failed,
    input logic       length_mismatch
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        length_valid && length_stall |=> length_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        length_valid && length_stall |=>
            $stable(insn_length) && $stable(decode_failed) && $stable(length_mismatch))
        else $error("stalled result word changed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        length_valid |-> (decode_failed == (insn_length == 4'd0)))
        else $error("decode_failed disagrees with insn_length");

    a_mismatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        length_valid && length_mismatch |-> !decode_failed)
        else $error("mismatch flagged on failed decode");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        window_stall |-> length_valid && length_stall)
        else $error("input stalled while output not blocked");

endmodule

bind x86_exit_instruction_length xeil_checker u_xeil_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .window_stall    (window_stall),
    .length_valid    (length_valid),
    .length_stall    (length_stall),
    .insn_length     (insn_length),
    .decode_failed   (decode_failed),
    .length_mismatch (length_mismatch)
);

### tb/sv/x86_exit_instruction_length_tb.sv
`timescale 1ns / 100ps

module x86_exit_instruction_length_tb;

    localparam int N_RANDOM    = 1820;
    localparam int CALM_ITEMS  = 200;
    localparam int LONG_HOLD   = 80;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 30;

    localparam logic [7:0] OP_UNLISTED = 8'h05;

    typedef bit [xeil_pkg::WIN_W-1:0] win_t;

    typedef struct {
        bit [3:0] len;
        bit       failed;
        bit       mismatch;
    } length_result_t;

    bit [7:0] pfx_codes [11] = '{xeil_pkg::PFX_ES, xeil_pkg::PFX_CS, xeil_pkg::PFX_SS,
                                 xeil_pkg::PFX_DS, xeil_pkg::PFX_FS, xeil_pkg::PFX_GS,
                                 xeil_pkg::PFX_OPSZ, xeil_pkg::PFX_ADSZ,
                                 xeil_pkg::PFX_LOCK, xeil_pkg::PFX_REPNE,
                                 xeil_pkg::PFX_REP};
    bit [7:0] op_codes [10] = '{xeil_pkg::OP_GRP7, xeil_pkg::OP_INVD, xeil_pkg::OP_MOVCR,
                                xeil_pkg::OP_MOVTOCR, xeil_pkg::OP_WRMSR,
                                xeil_pkg::OP_RDTSC, xeil_pkg::OP_RDMSR,
                                xeil_pkg::OP_GETSEC, xeil_pkg::OP_CPUID,
                                xeil_pkg::OP_GRP9};
    bit [7:0] plain_ops [6] = '{xeil_pkg::OP_CPUID, xeil_pkg::OP_INVD, xeil_pkg::OP_WRMSR,
                                xeil_pkg::OP_RDTSC, xeil_pkg::OP_RDMSR,
                                xeil_pkg::OP_GETSEC};
    bit [7:0] grp7_modrm [7] = '{xeil_pkg::RM_VMCALL, xeil_pkg::RM_VMLAUNCH,
                                 xeil_pkg::RM_VMRESUME, xeil_pkg::RM_VMXOFF,
                                 xeil_pkg::RM_XSETBV, xeil_pkg::RM_VMFUNC,
                                 xeil_pkg::RM_RDTSCP};

    class length_scoreboard;
        length_result_t expected_q[$];
        int unsigned    errors;

        function new();
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function automatic int unsigned decoded_length(bit fok, win_t w);
            bit [7:0]    b [xeil_pkg::WINDOW_BYTES];
            int unsigned p;
            int unsigned e;
            bit [7:0]    op;
            bit [7:0]    m;
            bit [7:0]    sib;
            bit [1:0]    md;
            bit          scanning;
            if (!fok)
                return 0;
            for (int k = 0; k < xeil_pkg::WINDOW_BYTES; k++)
                b[k] = w[8*k +: 8];
            p = 0;
            scanning = 1'b1;
            while (scanning && p < xeil_pkg::WINDOW_BYTES)
            begin
                case (b[p])
                    xeil_pkg::PFX_ES, xeil_pkg::PFX_CS, xeil_pkg::PFX_SS,
                    xeil_pkg::PFX_DS, xeil_pkg::PFX_FS, xeil_pkg::PFX_GS,
                    xeil_pkg::PFX_OPSZ, xeil_pkg::PFX_ADSZ, xeil_pkg::PFX_LOCK,
                    xeil_pkg::PFX_REPNE, xeil_pkg::PFX_REP: p++;
                    default: scanning = 1'b0;
                endcase
            end
            if (p < xeil_pkg::WINDOW_BYTES && b[p][7:4] == xeil_pkg::REX_HI)
                p++;
            if (p + 1 >= xeil_pkg::WINDOW_BYTES || b[p] != xeil_pkg::ESC_0F)
                return 0;
            op = b[p+1];
            p = p + 2;
            case (op)
                xeil_pkg::OP_INVD, xeil_pkg::OP_WRMSR, xeil_pkg::OP_RDTSC,
                xeil_pkg::OP_RDMSR, xeil_pkg::OP_GETSEC, xeil_pkg::OP_CPUID:
                    return p;
                xeil_pkg::OP_GRP7:
                begin
                    if (p >= xeil_pkg::WINDOW_BYTES)
                        return 0;
                    m = b[p];
                    case (m)
                        xeil_pkg::RM_VMCALL, xeil_pkg::RM_VMLAUNCH, xeil_pkg::RM_VMRESUME,
                        xeil_pkg::RM_VMXOFF, xeil_pkg::RM_XSETBV, xeil_pkg::RM_VMFUNC,
                        xeil_pkg::RM_RDTSCP: return p + 1;
                        default: return (m[5:3] == xeil_pkg::REG_LMSW) ? p + 1 : 0;
                    endcase
                end
                xeil_pkg::OP_MOVCR, xeil_pkg::OP_MOVTOCR, xeil_pkg::OP_GRP9:
                begin
                    if (p >= xeil_pkg::WINDOW_BYTES)
                        return 0;
                    m = b[p];
                    md = m[7:6];
                    e = p + 1;
                    if (md != xeil_pkg::MOD_REG)
                    begin
                        if (m[2:0] == xeil_pkg::RM_SIB)
                        begin
                            if (e >= xeil_pkg::WINDOW_BYTES)
                                return 0;
                            sib = b[e];
                            e++;
                            if (md == xeil_pkg::MOD_IND && sib[2:0] == xeil_pkg::RM_DISP)
                                e += 4;
                            else if (md == xeil_pkg::MOD_DISP8)
                                e += 1;
                            else if (md == xeil_pkg::MOD_DISP32)
                                e += 4;
                        end
                        else if (md == xeil_pkg::MOD_IND && m[2:0] == xeil_pkg::RM_DISP)
                            e += 4;
                        else if (md == xeil_pkg::MOD_DISP8)
                            e += 1;
                        else if (md == xeil_pkg::MOD_DISP32)
                            e += 4;
                    end
                    return (e <= xeil_pkg::WINDOW_BYTES) ? e : 0;
                end
                default:
                    return 0;
            endcase
        endfunction

        function void note_window(bit fok, win_t w, bit [xeil_pkg::REP_W-1:0] rep);
            length_result_t r;
            int unsigned    len;
            len = decoded_length(fok, w);
            r.len = 4'(len);
            r.failed = (len == 0);
            r.mismatch = (len != 0) && (len != rep);
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("%0t length check: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(bit [3:0] len, bit failed, bit mismatch);
            length_result_t r;
            if (expected_q.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            r = expected_q.pop_front();
            if (len != r.len)
                report($sformatf("insn_length %0d, expected %0d", len, r.len));
            if (failed != r.failed)
                report($sformatf("decode_failed %0b, expected %0b", failed, r.failed));
            if (mismatch != r.mismatch)
                report($sformatf("length_mismatch %0b, expected %0b", mismatch, r.mismatch));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        window_valid = 1'b0;
    logic                        window_stall;
    logic                        fetch_ok = 1'b0;
    logic [63:0]                 window_low = '0;
    logic [55:0]                 window_high = '0;
    logic [xeil_pkg::REP_W-1:0]  reported_length = '0;
    logic                        length_valid;
    logic                        length_stall = 1'b0;
    logic [3:0]                  insn_length;
    logic                        decode_failed;
    logic                        length_mismatch;

    length_scoreboard  sb;
    bit                calm = 1'b0;
    bit                tx_idle_on = 1'b1;
    bit                rx_idle_on = 1'b1;
    bit                hold_req = 1'b0;
    int unsigned       stuck_cycles = 0;

    x86_exit_instruction_length u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .window_valid    (window_valid),
        .window_stall    (window_stall),
        .fetch_ok        (fetch_ok),
        .window_low      (window_low),
        .window_high     (window_high),
        .reported_length (reported_length),
        .length_valid    (length_valid),
        .length_stall    (length_stall),
        .insn_length     (insn_length),
        .decode_failed   (decode_failed),
        .length_mismatch (length_mismatch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // first n bytes from lead, the rest of the window NOP filler
    function automatic win_t lead_bytes(win_t lead, int n);
        win_t mask;
        mask = (win_t'(1) << (8 * n)) - win_t'(1);
        return (lead & mask) | ({xeil_pkg::WINDOW_BYTES{8'h90}} & ~mask);
    endfunction

    // mostly well-formed encodings with random operands; some noise and corruption
    function automatic win_t random_window();
        bit [7:0] b [xeil_pkg::WINDOW_BYTES];
        win_t     w;
        bit [7:0] op;
        int       p;
        int       n_pfx;
        int       shape;
        for (int k = 0; k < xeil_pkg::WINDOW_BYTES; k++)
            b[k] = 8'($urandom);
        shape = $urandom_range(0, 9);
        p = 0;
        if (shape != 0)
        begin
            if ($urandom_range(0, 9) == 0)
                n_pfx = $urandom_range(0, xeil_pkg::WINDOW_BYTES);
            else
                n_pfx = $urandom_range(0, 3);
            while (p < n_pfx)
            begin
                b[p] = pfx_codes[$urandom_range(0, 10)];
                p++;
            end
            if (p < xeil_pkg::WINDOW_BYTES && $urandom_range(0, 1) == 1)
            begin
                b[p] = {xeil_pkg::REX_HI, 4'($urandom)};
                p++;
            end
            if (p < xeil_pkg::WINDOW_BYTES)
            begin
                b[p] = xeil_pkg::ESC_0F;
                p++;
            end
            if (p < xeil_pkg::WINDOW_BYTES)
            begin
                op = op_codes[$urandom_range(0, 9)];
                b[p] = op;
                p++;
                if (p < xeil_pkg::WINDOW_BYTES && op == xeil_pkg::OP_GRP7)
                begin
                    case ($urandom_range(0, 2))
                        0: b[p] = grp7_modrm[$urandom_range(0, 6)];
                        1: b[p][5:3] = xeil_pkg::REG_LMSW;
                        default: ;
                    endcase
                end
            end
            if (shape == 1)
                b[$urandom_range(0, xeil_pkg::WINDOW_BYTES - 1)] = 8'($urandom);
        end
        for (int k = 0; k < xeil_pkg::WINDOW_BYTES; k++)
            w[8*k +: 8] = b[k];
        return w;
    endfunction

    task automatic send_word(bit fok, win_t w, bit [xeil_pkg::REP_W-1:0] rep);
        window_valid <= 1'b1;
        fetch_ok <= fok;
        window_low <= w[63:0];
        window_high <= w[xeil_pkg::WIN_W-1:64];
        reported_length <= rep;
        @(posedge clk);
        while (window_stall)
            @(posedge clk);
        if (!calm && tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            window_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        int stall_left;
        int rx_cycle;
        stall_left = 0;
        rx_cycle = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (rx_cycle % 100 == 0)
                rx_idle_on = ($urandom_range(0, 2) != 0);
            if (stall_left > 0)
            begin
                length_stall <= 1'b1;
                stall_left--;
            end
            else if (!calm && rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                length_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end
            else
                length_stall <= 1'b0;
            rx_cycle++;
        end
    end

    // word capture, result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (window_valid && !window_stall)
                sb.note_window(fetch_ok, {window_high, window_low}, reported_length);
            if (length_valid && !length_stall)
                sb.check_result(insn_length, decode_failed, length_mismatch);
            if ((window_valid && !window_stall) || (length_valid && !length_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[x86_exit_instruction_length] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        win_t                       w;
        bit                         fok;
        bit [xeil_pkg::REP_W-1:0]   rep;
        int unsigned                len;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 6; k++)
            send_word(1'b1, lead_bytes(win_t'({plain_ops[k], xeil_pkg::ESC_0F}), 2),
                      (k == 1) ? 6'd3 : 6'd2);
        for (int k = 0; k < 7; k++)
            send_word(1'b1, lead_bytes(win_t'({grp7_modrm[k], xeil_pkg::OP_GRP7,
                                               xeil_pkg::ESC_0F}), 3), 6'd3);
        send_word(1'b1, lead_bytes(win_t'({xeil_pkg::MOD_REG, xeil_pkg::REG_LMSW, 3'd0,
                                           xeil_pkg::OP_GRP7, xeil_pkg::ESC_0F}), 3), 6'd3);
        send_word(1'b1, lead_bytes(win_t'({xeil_pkg::MOD_REG, 3'd0, xeil_pkg::RM_DISP,
                                           xeil_pkg::OP_GRP7, xeil_pkg::ESC_0F}), 3), 6'd3);
        send_word(1'b1, lead_bytes(win_t'({xeil_pkg::MOD_REG, 6'd0, xeil_pkg::OP_MOVCR,
                                           xeil_pkg::ESC_0F}), 3), 6'd3);
        send_word(1'b1, lead_bytes(win_t'({32'h44332211, 2'd0, 3'd4, xeil_pkg::RM_DISP,
                                           xeil_pkg::MOD_IND, 3'd0, xeil_pkg::RM_SIB,
                                           xeil_pkg::OP_MOVTOCR, xeil_pkg::ESC_0F}), 8),
                  6'd8);
        send_word(1'b1, lead_bytes(win_t'({32'h80706050, xeil_pkg::MOD_DISP32, 6'd0,
                                           xeil_pkg::OP_GRP9, xeil_pkg::ESC_0F}), 7),
                  6'd7);
        send_word(1'b1, lead_bytes(win_t'({8'h08, 8'h24, xeil_pkg::MOD_DISP8, 3'd0,
                                           xeil_pkg::RM_SIB, xeil_pkg::OP_MOVCR,
                                           xeil_pkg::ESC_0F}), 5), 6'd9);
        send_word(1'b1, lead_bytes(win_t'({xeil_pkg::OP_CPUID, xeil_pkg::ESC_0F,
                                           xeil_pkg::REX_HI, 4'h8, xeil_pkg::PFX_REP,
                                           xeil_pkg::PFX_OPSZ}), 5), 6'd5);
        send_word(1'b1, {xeil_pkg::OP_CPUID, xeil_pkg::ESC_0F, xeil_pkg::PFX_REPNE,
                         xeil_pkg::PFX_GS, xeil_pkg::PFX_FS, xeil_pkg::PFX_DS,
                         xeil_pkg::PFX_SS, xeil_pkg::PFX_CS, xeil_pkg::PFX_ES,
                         xeil_pkg::PFX_ADSZ, xeil_pkg::PFX_OPSZ, xeil_pkg::PFX_LOCK,
                         xeil_pkg::PFX_REP, xeil_pkg::PFX_OPSZ, xeil_pkg::PFX_ES}, 6'd15);
        send_word(1'b1, {xeil_pkg::WINDOW_BYTES{xeil_pkg::PFX_OPSZ}}, 6'd1);
        send_word(1'b1, {xeil_pkg::ESC_0F, {14{xeil_pkg::PFX_CS}}}, 6'd15);
        send_word(1'b1, {xeil_pkg::OP_GRP7, xeil_pkg::ESC_0F, xeil_pkg::REX_HI, 4'hf,
                         {12{xeil_pkg::PFX_SS}}}, 6'd15);
        send_word(1'b1, {xeil_pkg::MOD_IND, 3'd0, xeil_pkg::RM_SIB, xeil_pkg::OP_GRP9,
                         xeil_pkg::ESC_0F, {12{xeil_pkg::PFX_DS}}}, 6'd15);
        send_word(1'b1, {8'h00, xeil_pkg::MOD_DISP32, 6'd0, xeil_pkg::OP_MOVCR,
                         xeil_pkg::ESC_0F, {11{xeil_pkg::PFX_FS}}}, 6'd15);
        send_word(1'b0, lead_bytes(win_t'({xeil_pkg::OP_CPUID, xeil_pkg::ESC_0F}), 2),
                  6'd2);
        send_word(1'b1, lead_bytes(win_t'({OP_UNLISTED, xeil_pkg::ESC_0F}), 2), 6'd2);
        send_word(1'b1, '0, 6'd0);
        send_word(1'b1, '1, 6'd63);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 600)
                hold_req = 1'b1;
            if (i == 1200)
            begin
                window_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (i == N_RANDOM - CALM_ITEMS)
                calm = 1'b1;
            if (i % 128 == 0)
                tx_idle_on = ($urandom_range(0, 2) != 0);
            w = random_window();
            fok = ($urandom_range(0, 15) != 0);
            len = sb.decoded_length(fok, w);
            case ($urandom_range(0, 4))
                0, 1, 2: rep = 6'(len);
                3: rep = 6'(len) + ($urandom_range(0, 1) == 1 ? 6'd1 : 6'd63);
                default: rep = 6'($urandom_range(0, 63));
            endcase
            send_word(fok, w, rep);
        end
        window_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("[x86_exit_instruction_length] OK");
        else
            $display("[x86_exit_instruction_length] ERROR");
        $finish;
    end

endmodule
